FILE: src/lswc_pkg.sv
// ----------------------------------------------------------------------------
// lswc_pkg
// shared types, constants and helpers for the line segment window clipper
// ----------------------------------------------------------------------------
package lswc_pkg;

  localparam int COORD_W        = 16;
  localparam int DIFF_W         = COORD_W + 1;
  localparam int DIVD_W         = 2 * DIFF_W;
  localparam int DIV_STEPS      = DIVD_W - 1;
  localparam int DIV_CNT_W      = $clog2(DIV_STEPS + 1);
  localparam int MAX_CLIP_STEPS = 8;
  localparam int STEP_W         = $clog2(MAX_CLIP_STEPS + 1);
  localparam int CFG_IDX_W      = 2;

  localparam logic [3:0] CODE_LEFT   = 4'd1;
  localparam logic [3:0] CODE_RIGHT  = 4'd2;
  localparam logic [3:0] CODE_BOTTOM = 4'd4;
  localparam logic [3:0] CODE_TOP    = 4'd8;

  localparam logic [CFG_IDX_W-1:0] REG_X_MIN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_Y_MIN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_X_MAX = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_Y_MAX = 2'd3;

  localparam logic signed [COORD_W-1:0] RST_X_MIN = 16'sd0;
  localparam logic signed [COORD_W-1:0] RST_Y_MIN = 16'sd0;
  localparam logic signed [COORD_W-1:0] RST_X_MAX = 16'sd639;
  localparam logic signed [COORD_W-1:0] RST_Y_MAX = 16'sd479;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [DIFF_W-1:0]  diff_t;
  typedef logic signed [DIVD_W-1:0]  divd_t;

  typedef struct packed {
    coord_t start_x;
    coord_t start_y;
    coord_t end_x;
    coord_t end_y;
  } seg_in_t;

  typedef struct packed {
    logic   accepted;
    coord_t clipped_start_x;
    coord_t clipped_start_y;
    coord_t clipped_end_x;
    coord_t clipped_end_y;
  } seg_out_t;

  typedef struct packed {
    logic  start;
    divd_t dividend;
    diff_t divisor;
  } div_req_t;

  typedef struct packed {
    logic  done;
    divd_t quotient;
  } div_rsp_t;

  function automatic logic [3:0] region_code(coord_t x, coord_t y, coord_t xmin,
                                             coord_t ymin, coord_t xmax, coord_t ymax);
    logic [3:0] c;
    c = 4'd0;
    if (y > ymax) c = c | CODE_TOP;
    if (y < ymin) c = c | CODE_BOTTOM;
    if (x > xmax) c = c | CODE_RIGHT;
    if (x < xmin) c = c | CODE_LEFT;
    return c;
  endfunction

endpackage

FILE: src/lswc_div.sv
// ----------------------------------------------------------------------------
// lswc_div
// serial signed divider, one quotient bit per cycle, truncates toward zero
// ----------------------------------------------------------------------------
module lswc_div (
  input  logic               clk,
  input  logic               rst_n,
  input  lswc_pkg::div_req_t req,
  output lswc_pkg::div_rsp_t rsp
);
  import lswc_pkg::*;

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                 neg_r, neg_nxt;
  logic [DIVD_W-2:0]    quo_r, quo_nxt;
  logic [COORD_W-1:0]   rem_r, rem_nxt;
  logic [COORD_W-1:0]   dvs_r, dvs_nxt;

  divd_t             divd_abs;
  diff_t             dvs_abs;
  logic [COORD_W:0]  shifted;
  logic [COORD_W:0]  diff;
  logic              fits;

  always_comb begin
    divd_abs = req.dividend[DIVD_W-1] ? -req.dividend : req.dividend;
    dvs_abs  = req.divisor[DIFF_W-1] ? -req.divisor : req.divisor;
    shifted  = {rem_r, quo_r[DIVD_W-2]};
    diff     = shifted - {1'b0, dvs_r};
    fits     = shifted >= {1'b0, dvs_r};

    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    neg_nxt  = neg_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = DIV_CNT_W'(DIV_STEPS);
      neg_nxt  = req.dividend[DIVD_W-1] ^ req.divisor[DIFF_W-1];
      quo_nxt  = divd_abs[DIVD_W-2:0];
      rem_nxt  = '0;
      dvs_nxt  = dvs_abs[COORD_W-1:0];
    end else if (busy_r) begin
      quo_nxt = {quo_r[DIVD_W-3:0], fits};
      rem_nxt = fits ? diff[COORD_W-1:0] : shifted[COORD_W-1:0];
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == DIV_CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    neg_r <= neg_nxt;
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = neg_r ? -divd_t'({1'b0, quo_r}) : divd_t'({1'b0, quo_r});

endmodule

FILE: src/line_segment_window_clipper_core.sv
// ----------------------------------------------------------------------------
// line_segment_window_clipper_core
// region-code line clipper with one multiplier and a shared serial divider
// ----------------------------------------------------------------------------
// one request at a time; each endpoint move runs multiply, divide and update, at most
// 8 moves per segment, mostly spent in the 33-step serial divider; the result waits
// in S_TEST while the previous result is still held at the output
// in_ready is high only while the sequencer is idle
// synchronous active-low reset: window returns to 0,0 .. 639,479, no result held
// ----------------------------------------------------------------------------
module line_segment_window_clipper_core (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  lswc_pkg::seg_in_t                   in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output lswc_pkg::seg_out_t                  out_data,
  input  logic                                cfg_we,
  input  logic [lswc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [lswc_pkg::COORD_W-1:0]        cfg_wdata
);
  import lswc_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_TEST = 3'd1;
  localparam logic [2:0] S_MUL  = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_WAIT = 3'd4;
  localparam logic [2:0] S_UPD  = 3'd5;

  logic [2:0]  state_r, state_nxt;
  coord_t      xmin_r, ymin_r, xmax_r, ymax_r;
  coord_t      ax_r, ay_r, bx_r, by_r;
  coord_t      ax_nxt, ay_nxt, bx_nxt, by_nxt;
  logic [STEP_W-1:0] steps_r, steps_nxt;
  diff_t       num_r, num_nxt;
  diff_t       fac_r, fac_nxt;
  diff_t       dvs_r, dvs_nxt;
  coord_t      edge_r, edge_nxt;
  coord_t      base_r, base_nxt;
  logic        along_y_r, along_y_nxt;
  logic        move_a_r, move_a_nxt;
  divd_t       prod_r, prod_nxt;
  logic        out_valid_r, out_valid_nxt;
  seg_out_t    out_r, out_nxt;

  logic [3:0]  ca, cb, csel;
  diff_t       dx, dy;
  coord_t      edge_sel, new_c;
  logic        decided, acc;
  div_req_t    div_req;
  div_rsp_t    div_rsp;

  lswc_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign div_req.start    = (state_r == S_DIV);
  assign div_req.dividend = prod_r;
  assign div_req.divisor  = dvs_r;

  always_comb begin
    ca      = region_code(ax_r, ay_r, xmin_r, ymin_r, xmax_r, ymax_r);
    cb      = region_code(bx_r, by_r, xmin_r, ymin_r, xmax_r, ymax_r);
    csel    = (ca != 4'd0) ? ca : cb;
    dx      = diff_t'(bx_r) - diff_t'(ax_r);
    dy      = diff_t'(by_r) - diff_t'(ay_r);
    acc     = (ca == 4'd0) && (cb == 4'd0);
    decided = acc || ((ca & cb) != 4'd0) || (steps_r == STEP_W'(MAX_CLIP_STEPS));
    if ((csel & CODE_TOP) != 4'd0)         edge_sel = ymax_r;
    else if ((csel & CODE_BOTTOM) != 4'd0) edge_sel = ymin_r;
    else if ((csel & CODE_RIGHT) != 4'd0)  edge_sel = xmax_r;
    else                                   edge_sel = xmin_r;
    new_c = base_r + div_rsp.quotient[COORD_W-1:0];

    state_nxt     = state_r;
    ax_nxt        = ax_r;
    ay_nxt        = ay_r;
    bx_nxt        = bx_r;
    by_nxt        = by_r;
    steps_nxt     = steps_r;
    num_nxt       = num_r;
    fac_nxt       = fac_r;
    dvs_nxt       = dvs_r;
    edge_nxt      = edge_r;
    base_nxt      = base_r;
    along_y_nxt   = along_y_r;
    move_a_nxt    = move_a_r;
    prod_nxt      = prod_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_ready;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          ax_nxt    = in_data.start_x;
          ay_nxt    = in_data.start_y;
          bx_nxt    = in_data.end_x;
          by_nxt    = in_data.end_y;
          steps_nxt = '0;
          state_nxt = S_TEST;
        end
      end
      S_TEST: begin
        if (decided) begin
          if (!out_valid_r || out_ready) begin
            out_nxt.accepted        = acc;
            out_nxt.clipped_start_x = acc ? ax_r : '0;
            out_nxt.clipped_start_y = acc ? ay_r : '0;
            out_nxt.clipped_end_x   = acc ? bx_r : '0;
            out_nxt.clipped_end_y   = acc ? by_r : '0;
            out_valid_nxt           = 1'b1;
            state_nxt               = S_IDLE;
          end
        end else begin
          along_y_nxt = (csel & (CODE_TOP | CODE_BOTTOM)) != 4'd0;
          move_a_nxt  = (ca != 4'd0);
          edge_nxt    = edge_sel;
          if (along_y_nxt) begin
            num_nxt  = diff_t'(edge_sel) - diff_t'(ay_r);
            fac_nxt  = dx;
            dvs_nxt  = dy;
            base_nxt = ax_r;
          end else begin
            num_nxt  = diff_t'(edge_sel) - diff_t'(ax_r);
            fac_nxt  = dy;
            dvs_nxt  = dx;
            base_nxt = ay_r;
          end
          steps_nxt = steps_r + 1'b1;
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        prod_nxt  = divd_t'(num_r) * divd_t'(fac_r);
        state_nxt = S_DIV;
      end
      S_DIV: begin
        state_nxt = S_WAIT;
      end
      S_WAIT: begin
        if (div_rsp.done) state_nxt = S_UPD;
      end
      S_UPD: begin
        if (move_a_r) begin
          ax_nxt = along_y_r ? new_c : edge_r;
          ay_nxt = along_y_r ? edge_r : new_c;
        end else begin
          bx_nxt = along_y_r ? new_c : edge_r;
          by_nxt = along_y_r ? edge_r : new_c;
        end
        state_nxt = S_TEST;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      xmin_r      <= RST_X_MIN;
      ymin_r      <= RST_Y_MIN;
      xmax_r      <= RST_X_MAX;
      ymax_r      <= RST_Y_MAX;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          REG_X_MIN: xmin_r <= cfg_wdata;
          REG_Y_MIN: ymin_r <= cfg_wdata;
          REG_X_MAX: xmax_r <= cfg_wdata;
          REG_Y_MAX: ymax_r <= cfg_wdata;
          default:   ;
        endcase
      end
    end
    ax_r      <= ax_nxt;
    ay_r      <= ay_nxt;
    bx_r      <= bx_nxt;
    by_r      <= by_nxt;
    steps_r   <= steps_nxt;
    num_r     <= num_nxt;
    fac_r     <= fac_nxt;
    dvs_r     <= dvs_nxt;
    edge_r    <= edge_nxt;
    base_r    <= base_nxt;
    along_y_r <= along_y_nxt;
    move_a_r  <= move_a_nxt;
    prod_r    <= prod_nxt;
    out_r     <= out_nxt;
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

FILE: sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the region-code line segment window clipper: a
// scoreboard predicts every clipped segment and checks it against the block,
// over a run of directed segments, random segments and several clip windows,
// with random idling on both channels and a long output hold-off
// ----------------------------------------------------------------------------
module testbench;
  import lswc_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int HOLD_CYCLES    = 400;
  localparam int TAIL_CYCLES    = 300;

  class clip_scoreboard;
    longint   win_x_min;
    longint   win_y_min;
    longint   win_x_max;
    longint   win_y_max;
    seg_out_t pending_clips[$];
    int       failures;

    function new();
      win_x_min = RST_X_MIN;
      win_y_min = RST_Y_MIN;
      win_x_max = RST_X_MAX;
      win_y_max = RST_Y_MAX;
      failures  = 0;
    endfunction

    function void set_register(logic [CFG_IDX_W-1:0] idx, coord_t val);
      case (idx)
        REG_X_MIN: win_x_min = val;
        REG_Y_MIN: win_y_min = val;
        REG_X_MAX: win_x_max = val;
        REG_Y_MAX: win_y_max = val;
        default: ;
      endcase
    endfunction

    function logic [3:0] outcode(longint x, longint y);
      logic [3:0] c;
      c = 4'd0;
      if (y > win_y_max) c = c | CODE_TOP;
      if (y < win_y_min) c = c | CODE_BOTTOM;
      if (x > win_x_max) c = c | CODE_RIGHT;
      if (x < win_x_min) c = c | CODE_LEFT;
      return c;
    endfunction

    function seg_out_t clip_segment(seg_in_t s);
      longint     ax, ay, bx, by, nx, ny, dx, dy;
      logic [3:0] ca, cb, c;
      int         moves;
      seg_out_t   r;
      ax = s.start_x;
      ay = s.start_y;
      bx = s.end_x;
      by = s.end_y;
      ca = outcode(ax, ay);
      cb = outcode(bx, by);
      moves = 0;
      r = '0;
      forever begin
        if (ca == 4'd0 && cb == 4'd0) begin
          r = '{1'b1, coord_t'(ax), coord_t'(ay), coord_t'(bx), coord_t'(by)};
          break;
        end
        if ((ca & cb) != 4'd0 || moves >= MAX_CLIP_STEPS) break;
        moves++;
        c  = (ca != 4'd0) ? ca : cb;
        dx = bx - ax;
        dy = by - ay;
        // top beats bottom, right beats left
        if ((c & (CODE_TOP | CODE_BOTTOM)) != 4'd0) begin
          ny = ((c & CODE_TOP) != 4'd0) ? win_y_max : win_y_min;
          nx = (dy != 0) ? ax + (ny - ay) * dx / dy : ax;
        end else begin
          nx = ((c & CODE_RIGHT) != 4'd0) ? win_x_max : win_x_min;
          ny = (dx != 0) ? ay + (nx - ax) * dy / dx : ay;
        end
        if (ca != 4'd0) begin
          ax = nx;
          ay = ny;
          ca = outcode(ax, ay);
        end else begin
          bx = nx;
          by = ny;
          cb = outcode(bx, by);
        end
      end
      return r;
    endfunction

    function void note_request(seg_in_t s);
      pending_clips.push_back(clip_segment(s));
    endfunction

    function int pending();
      return pending_clips.size();
    endfunction

    function void compare_field(string field, logic signed [COORD_W:0] want,
                                logic signed [COORD_W:0] got);
      if (want !== got) begin
        $error("%s expected %0d got %0d", field, want, got);
        failures++;
      end
    endfunction

    function void check_result(seg_out_t got);
      seg_out_t want;
      if (pending_clips.size() == 0) begin
        $error("result with no request outstanding: %p", got);
        failures++;
        return;
      end
      want = pending_clips.pop_front();
      compare_field("accepted", want.accepted, got.accepted);
      compare_field("clipped_start_x", want.clipped_start_x, got.clipped_start_x);
      compare_field("clipped_start_y", want.clipped_start_y, got.clipped_start_y);
      compare_field("clipped_end_x", want.clipped_end_x, got.clipped_end_x);
      compare_field("clipped_end_y", want.clipped_end_y, got.clipped_end_y);
    endfunction
  endclass

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  seg_in_t              in_data;
  logic                 out_valid;
  logic                 out_ready;
  seg_out_t             out_data;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [COORD_W-1:0]   cfg_wdata;

  clip_scoreboard sb;
  bit             stalls_on = 1'b1;
  bit             hold_off  = 1'b0;
  int             quiet_cycles = 0;

  // default window 0,0 .. 639,479
  int corner_lines [20][4] = '{
    '{10, 10, 600, 400},
    '{-50, 10, -10, 400},
    '{100, 500, 300, 700},
    '{100, 400, 200, 600},
    '{100, -100, 200, 100},
    '{600, 100, 800, 200},
    '{-100, 100, 100, 200},
    '{320, -500, 320, 900},
    '{-500, 240, 900, 240},
    '{-100, -100, 800, 600},
    '{-100, 300, 100, 700},
    '{-32768, -32768, 32767, 32767},
    '{32767, -32768, -32768, 32767},
    '{0, 0, 639, 479},
    '{5, 5, 5, 5},
    '{-32768, 32767, -32768, 32767},
    '{32767, 32767, 32767, 32767},
    '{300, -32768, 301, 32767},
    '{700, -50, 500, 100},
    '{320, 240, 320, 32767}
  };

  line_segment_window_clipper_core u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic coord_t pick_coord(longint a, longint b);
    longint lo, hi, m, v;
    lo = (a < b) ? a : b;
    hi = (a < b) ? b : a;
    m  = (hi - lo) / 4 + 8;
    case ($urandom_range(0, 9))
      0, 1: v = coord_t'($urandom());
      2: begin
        case ($urandom_range(0, 5))
          0: v = -32768;
          1: v = 32767;
          2: v = lo;
          3: v = hi;
          4: v = lo - 1;
          default: v = hi + 1;
        endcase
      end
      default: v = lo - m + longint'($urandom_range(0, 32'(hi - lo + 2 * m)));
    endcase
    if (v < -32768) v = -32768;
    if (v > 32767) v = 32767;
    return coord_t'(v);
  endfunction

  function automatic seg_in_t random_segment();
    seg_in_t s;
    s.start_x = pick_coord(sb.win_x_min, sb.win_x_max);
    s.start_y = pick_coord(sb.win_y_min, sb.win_y_max);
    s.end_x   = pick_coord(sb.win_x_min, sb.win_x_max);
    s.end_y   = pick_coord(sb.win_y_min, sb.win_y_max);
    return s;
  endfunction

  task automatic send_segment(input seg_in_t s);
    in_data  <= s;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    sb.note_request(s);
    if (stalls_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
  endtask

  task automatic send_random(input int count);
    repeat (count) send_segment(random_segment());
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input coord_t val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    sb.set_register(idx, val);
  endtask

  task automatic set_window(input coord_t xmin, input coord_t ymin,
                            input coord_t xmax, input coord_t ymax);
    write_reg(REG_X_MIN, xmin);
    write_reg(REG_Y_MIN, ymin);
    write_reg(REG_X_MAX, xmax);
    write_reg(REG_Y_MAX, ymax);
    cfg_we <= 1'b0;
  endtask

  // receiving side
  initial begin
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off = 1'b0;
        out_ready <= 1'b1;
      end else if (stalls_on && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_result(out_data);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || cfg_we) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  initial begin
    seg_in_t s;
    sb = new();
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_we    <= 1'b0;
    cfg_index <= '0;
    cfg_wdata <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    foreach (corner_lines[i]) begin
      s.start_x = coord_t'(corner_lines[i][0]);
      s.start_y = coord_t'(corner_lines[i][1]);
      s.end_x   = coord_t'(corner_lines[i][2]);
      s.end_y   = coord_t'(corner_lines[i][3]);
      send_segment(s);
    end
    send_random(76);
    drain();

    set_window(-16'sd32768, -16'sd32768, 16'sd32767, 16'sd32767);
    send_random(70);
    drain();

    // output held off while requests keep coming
    set_window(-16'sd20, -16'sd10, 16'sd25, 16'sd12);
    hold_off = 1'b1;
    send_random(80);
    drain();

    // inverted window
    set_window(16'sd100, 16'sd50, -16'sd100, -16'sd50);
    send_random(76);
    drain();

    set_window(16'sd7, -16'sd3, 16'sd7, -16'sd3);
    send_random(70);
    drain();

    set_window(-16'sd32768, -16'sd5000, 16'sd20000, 16'sd32767);
    send_random(80);
    drain();

    stalls_on = 1'b0;
    set_window(-16'sd1000, -16'sd800, -16'sd200, -16'sd100);
    send_random(90);
    drain();

    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.failures == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

FILE: filelist.f
src/lswc_pkg.sv
src/lswc_div.sv
src/line_segment_window_clipper_core.sv
sim/testbench.sv
